// ===== design/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and helpers of the integer to ascii unit
// used by itoa_ctrl, itoa_dp and integer_to_radix_ascii_unit; no dependencies
package itoa_pkg;

    // field widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    // quotient bits resolved per divide cycle
    localparam int SLICE = 4;

    // radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // take a new value
        logic div;    // divide step of the slice divider
        logic store;  // write remainder digit, bump count
        logic sign;   // put '-' in the output register
        logic rd;     // read next digit, count down
        logic emit;   // put the read digit in the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic quo_zero;  // quotient is zero
        logic full;      // store is full after this digit
        logic neg;       // a '-' leads the text
        logic cnt_zero;  // the digit just read is the last one
        logic out_free;  // output register can take a character
    } t_sts;

    // digit value to ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        if (d > DIGIT_MAX) begin
            digit_char = CH_A + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
        end else begin
            digit_char = CH_ZERO + CHAR_W'(d);
        end
    endfunction

endpackage

// ===== design/itoa_ctrl.sv =====
// itoa_ctrl: sequencer of the integer to ascii unit (divide, store, emit)
// depends on itoa_pkg for the command and status structs
module itoa_ctrl #(
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  itoa_pkg::t_sts i_sts,
    output itoa_pkg::t_cmd o_cmd
);
    import itoa_pkg::*;

    localparam int DIV_CYC = (VALUE_BITS + SLICE - 1) / SLICE;
    localparam int STEP_W  = $clog2(DIV_CYC);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_cmd              s_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        s_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    s_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                s_cmd.div = 1'b1;
                n_step    = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_CYC - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                s_cmd.store = 1'b1;
                n_step      = '0;
                if (i_sts.quo_zero || i_sts.full) begin
                    n_state = i_sts.neg ? S_SIGN : S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    s_cmd.sign = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                s_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    s_cmd.emit = 1'b1;
                    if (i_sts.cnt_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        s_cmd.rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = s_cmd;

endmodule

// ===== design/itoa_dp.sv =====
// itoa_dp: datapath of the integer to ascii unit: radix register, slice divider,
// digit memory and output register; depends on itoa_pkg
module itoa_dp #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    input  logic                                i_cfg_valid,
    input  logic [itoa_pkg::RADIX_W-1:0]        i_cfg_data,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last,
    input  itoa_pkg::t_cmd                      i_cmd,
    output itoa_pkg::t_sts                      o_sts
);
    import itoa_pkg::*;

    localparam int DIV_CYC = (VALUE_BITS + SLICE - 1) / SLICE;
    localparam int PAD     = DIV_CYC * SLICE;
    localparam int AW      = $clog2(MAX_DIGITS);
    localparam int CW      = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_DIGITS - 1);
    localparam logic [CW-1:0] LAST_NEG = CW'(MAX_DIGITS - 2);

    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] r_base;
    logic               r_neg;
    logic [PAD-1:0]     r_quo;
    logic [RADIX_W-1:0] r_rem;
    logic [CW-1:0]      r_cnt;
    logic [RADIX_W-1:0] r_mem [MAX_DIGITS];
    logic [RADIX_W-1:0] r_rd_data;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [RADIX_W-1:0]    s_base;
    logic                  s_neg;
    logic [VALUE_BITS-1:0] s_mag;
    logic [RADIX_W-1:0]    s_rem;
    logic [RADIX_W:0]      s_trial;
    logic [SLICE-1:0]      s_q;
    logic [CW-1:0]         s_rd_ptr;
    logic                  s_out_free;

    // radix register, to be written only while idle: the user must keep to this, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    // clamp radix into 2..36, sign and magnitude of the new value
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            s_base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            s_base = RADIX_MAX;
        end else begin
            s_base = r_radix;
        end
        s_neg = (s_base == RADIX_DEC) && i_value[VALUE_BITS-1];
        s_mag = s_neg ? (VALUE_BITS'(0) - VALUE_BITS'(i_value)) : VALUE_BITS'(i_value);
    end

    // restoring divide by the radix, SLICE quotient bits per cycle
    always_comb begin
        s_rem   = r_rem;
        s_trial = '0;
        s_q     = '0;
        for (int i = 0; i < SLICE; i++) begin
            s_trial = {s_rem, r_quo[PAD-1-i]};
            if (s_trial >= {1'b0, r_base}) begin
                s_rem          = RADIX_W'(s_trial - {1'b0, r_base});
                s_q[SLICE-1-i] = 1'b1;
            end else begin
                s_rem = s_trial[RADIX_W-1:0];
            end
        end
    end

    // working registers of the conversion
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= s_base;
            r_neg  <= s_neg;
            r_quo  <= PAD'(s_mag);
            r_rem  <= '0;
        end else if (i_cmd.div) begin
            r_quo <= {r_quo[PAD-SLICE-1:0], s_q};
            r_rem <= s_rem;
        end else if (i_cmd.store) begin
            r_rem <= '0;
        end
    end

    // digit count, later walked down as the read pointer
    assign s_rd_ptr = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.store) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.rd) begin
            r_cnt <= s_rd_ptr;
        end
    end

    // digit memory, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt[AW-1:0]] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[s_rd_ptr[AW-1:0]];
        end
    end

    // output register
    assign s_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sign || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sign) begin
            r_char <= CH_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit) begin
            r_char <= digit_char(r_rd_data);
            r_last <= (r_cnt == '0);
        end
    end

    // status to the controller
    assign o_sts.quo_zero = (r_quo == '0);
    assign o_sts.full     = (r_cnt == (r_neg ? LAST_NEG : LAST_POS));
    assign o_sts.neg      = r_neg;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = s_out_free;

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

`ifndef NO_ASSERTIONS
    // digit write stays inside the memory
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_cnt < CW'(MAX_DIGITS)))
        else $error("digit write beyond the store");

    // a read never runs below the first digit
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_cnt != '0))
        else $error("digit read with empty count");

    // a character is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sign || i_cmd.emit) |-> s_out_free)
        else $error("output register overwritten");

    // remainder stays below the base after each divide cycle
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |=> (r_rem < r_base))
        else $error("remainder not below radix");
`endif

endmodule

// ===== design/integer_to_radix_ascii_unit.sv =====
// integer_to_radix_ascii_unit: top level of the integer to ascii converter
// depends on itoa_pkg, itoa_ctrl and itoa_dp
//
// Converts one signed VALUE_BITS-bit value per request into ASCII text in the
// base held in the radix register (2..36, reset 10; 0 and 1 act as 2, above 36
// acts as 36), most significant character first, with o_last on the final
// one. Letters are lower case; zero gives "0"; only base 10 puts '-' before a
// negative value, other bases convert the raw unsigned bit pattern. Each digit
// is worked out in the shared slice divider, then the text leaves at one
// character per cycle while the output is not stalled, after a memory read,
// with any '-' first. A new value is taken once the last character is in the
// output register.
module integer_to_radix_ascii_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [itoa_pkg::RADIX_W-1:0] i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [itoa_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last
);
    import itoa_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    // radix writes must arrive only while idle; the user keeps to this, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    itoa_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    itoa_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts)
    );

endmodule
